// ----- src/sdh_pkg.sv -----
// ----------------------------------------------------------------------------
// sdh_pkg
// shared types, constants and helpers of the sd card spi host
// ----------------------------------------------------------------------------
package sdh_pkg;

   localparam int BLOCK_BYTES   = 512;
   localparam int POLL_TRIES    = 10;
   localparam int RETRY_TRIES   = 255;
   localparam int POWERUP_BYTES = 10;
   localparam int FIFO_DEPTH    = 4;

   localparam logic [7:0]  IDLE_BYTE  = 8'hFF;
   localparam logic [7:0]  DATA_TOKEN = 8'hFE;
   localparam logic [31:0] CMD8_ARG   = 32'h0000_01AA;
   localparam logic [31:0] ACMD41_ARG = 32'h4000_0000;

   localparam logic [7:0] CODE_CMD0   = 8'h40;
   localparam logic [7:0] CODE_CMD1   = 8'h41;
   localparam logic [7:0] CODE_CMD8   = 8'h48;
   localparam logic [7:0] CODE_CMD16  = 8'h50;
   localparam logic [7:0] CODE_ACMD41 = 8'h69;
   localparam logic [7:0] CODE_CMD55  = 8'h77;
   localparam logic [7:0] CODE_CMD58  = 8'h7A;
   localparam logic [7:0] CODE_CMD59  = 8'h7B;

   localparam logic [5:0] IDX_CMD0   = 6'd0;
   localparam logic [5:0] IDX_CMD1   = 6'd1;
   localparam logic [5:0] IDX_CMD8   = 6'd8;
   localparam logic [5:0] IDX_CMD16  = 6'd16;
   localparam logic [5:0] IDX_CMD17  = 6'd17;
   localparam logic [5:0] IDX_CMD24  = 6'd24;
   localparam logic [5:0] IDX_ACMD41 = 6'd41;
   localparam logic [5:0] IDX_CMD55  = 6'd55;
   localparam logic [5:0] IDX_CMD58  = 6'd58;
   localparam logic [5:0] IDX_CMD59  = 6'd59;

   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_SHUT  = 3'd3;
   localparam logic [2:0] OP_XDONE = 3'd4;
   localparam logic [2:0] OP_WBYTE = 3'd5;

   localparam logic [1:0] KIND_XFER = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_NEED = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;

   typedef enum logic [14:0] {
      PH_IDLE      = 15'h0001,
      PH_PWRUP     = 15'h0002,
      PH_READY     = 15'h0004,
      PH_FRAME     = 15'h0008,
      PH_POLL      = 15'h0010,
      PH_RD_TOKEN  = 15'h0020,
      PH_RD_DATA   = 15'h0040,
      PH_RD_CRC    = 15'h0080,
      PH_WR_TOKEN  = 15'h0100,
      PH_WR_NEED   = 15'h0200,
      PH_WR_DATA   = 15'h0400,
      PH_WR_CRC    = 15'h0800,
      PH_WR_RESP   = 15'h1000,
      PH_WR_BUSY   = 15'h2000,
      PH_END_CLOCK = 15'h4000
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] spi_byte;
      logic       select_active;
      logic [7:0] data_byte;
      logic       success;
      logic       last;
   } res_type;

   typedef struct packed {
      res_type    r0;
      res_type    r1;
      logic [1:0] n;
   } push_type;

   function automatic res_type mk_res(logic [1:0] kind, logic [7:0] spi, logic sel,
                                      logic [7:0] data, logic ok);
      res_type r;
      r.kind          = kind;
      r.spi_byte      = spi;
      r.select_active = sel;
      r.data_byte     = data;
      r.success       = ok;
      r.last          = 1'b0;
      return r;
   endfunction

   function automatic logic [7:0] crc_byte(logic [7:0] code);
      logic [7:0] c;
      case (code)
         CODE_CMD0:   c = 8'h95;
         CODE_CMD8:   c = 8'h87;
         CODE_CMD55:  c = 8'h65;
         CODE_ACMD41: c = 8'h77;
         CODE_CMD1:   c = 8'hF9;
         CODE_CMD58:  c = 8'hFD;
         default:     c = 8'hFF;
      endcase
      return c;
   endfunction

endpackage

// ----- src/sd_card_spi_block_host_core.sv -----
// ----------------------------------------------------------------------------
// sd_card_spi_block_host_core
// spi-mode sd card host sequencer with result queue
// ----------------------------------------------------------------------------
// Each accepted item is processed in the cycle it is accepted and its results,
// up to two, enter a four-entry result queue, so one item per clock is taken
// while at least two queue slots are free; req_stall rises only when the
// queue holds more than two results.
module sd_card_spi_block_host_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_block_address,
   input  logic [7:0]  req_miso_byte,
   input  logic [7:0]  req_write_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_spi_byte,
   output logic        rsp_select_active,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_success,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_byte_addressed_card
);

   sdh_pkg::push_type push;
   sdh_pkg::res_type  head;
   logic              take;
   logic              low_room;

   assign req_stall = low_room;
   assign take      = req_valid & ~low_room;
   assign csr_ready = 1'b1;

   sdh_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .op            (req_op),
      .block_address (req_block_address),
      .miso_byte     (req_miso_byte),
      .write_byte    (req_write_byte),
      .cfg_we        (csr_valid),
      .cfg_data      (csr_byte_addressed_card),
      .push          (push)
   );

   sdh_res_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid & ~rsp_stall),
      .not_empty (rsp_valid),
      .low_room  (low_room),
      .head      (head)
   );

   assign rsp_kind          = head.kind;
   assign rsp_spi_byte      = head.spi_byte;
   assign rsp_select_active = head.select_active;
   assign rsp_data_byte     = head.data_byte;
   assign rsp_success       = head.success;
   assign rsp_last          = head.last;

endmodule

// ----- src/sdh_seq.sv -----
// ----------------------------------------------------------------------------
// sdh_seq
// command sequencer: state registers and the per-item step logic
// ----------------------------------------------------------------------------
module sdh_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [2:0]        op,
   input  logic [31:0]       block_address,
   input  logic [7:0]        miso_byte,
   input  logic [7:0]        write_byte,
   input  logic              cfg_we,
   input  logic              cfg_data,
   output sdh_pkg::push_type push
);

   sdh_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  oper_ff, oper_in;
   logic [9:0]  bcnt_ff, bcnt_in;
   logic [3:0]  poll_ff, poll_in;
   logic [7:0]  retry_ff, retry_in;
   logic [31:0] arg_ff, arg_in;
   logic [7:0]  code_ff, code_in;
   logic        sel_ff, sel_in;
   logic        byte_addr_ff;

   always_comb begin
      logic        start_en;
      logic [5:0]  start_idx;
      logic [31:0] start_arg;
      logic        fin_en;
      logic        fin_ok;
      logic        resp_en;
      logic [7:0]  resp;
      logic        xfer_en;
      logic [7:0]  xfer_b;
      logic        pre_en;
      sdh_pkg::res_type pre_r;
      sdh_pkg::res_type main_r;
      logic        main_en;
      logic [31:0] addr;
      logic [9:0]  bnext;
      logic [3:0]  pnext;
      logic [7:0]  rnext;
      phase_in  = phase_ff;
      oper_in   = oper_ff;
      bcnt_in   = bcnt_ff;
      poll_in   = poll_ff;
      retry_in  = retry_ff;
      arg_in    = arg_ff;
      code_in   = code_ff;
      sel_in    = sel_ff;
      start_en  = 1'b0;
      start_idx = sdh_pkg::IDX_CMD0;
      start_arg = '0;
      fin_en    = 1'b0;
      fin_ok    = 1'b0;
      resp_en   = 1'b0;
      resp      = miso_byte;
      xfer_en   = 1'b0;
      xfer_b    = sdh_pkg::IDLE_BYTE;
      pre_en    = 1'b0;
      pre_r     = sdh_pkg::mk_res(sdh_pkg::KIND_DATA, '0, 1'b0, miso_byte, 1'b0);
      main_en   = 1'b0;
      main_r    = '0;
      addr      = byte_addr_ff ? {block_address[22:0], 9'd0} : block_address;
      bnext     = 10'(bcnt_ff + 10'd1);
      pnext     = 4'(poll_ff + 4'd1);
      rnext     = 8'(retry_ff + 8'd1);

      if (take) begin
         case (op)
            sdh_pkg::OP_INIT, sdh_pkg::OP_READ, sdh_pkg::OP_WRITE, sdh_pkg::OP_SHUT: begin
               if (phase_ff == sdh_pkg::PH_IDLE) begin
                  oper_in = op[1:0];
                  if (op == sdh_pkg::OP_INIT) begin
                     sel_in   = 1'b0;
                     bcnt_in  = '0;
                     phase_in = sdh_pkg::PH_PWRUP;
                     xfer_en  = 1'b1;
                  end else if (op == sdh_pkg::OP_READ) begin
                     start_en  = 1'b1;
                     start_idx = sdh_pkg::IDX_CMD17;
                     start_arg = addr;
                  end else if (op == sdh_pkg::OP_WRITE) begin
                     start_en  = 1'b1;
                     start_idx = sdh_pkg::IDX_CMD24;
                     start_arg = addr;
                  end else begin
                     phase_in = sdh_pkg::PH_END_CLOCK;
                     xfer_en  = 1'b1;
                  end
               end
            end
            sdh_pkg::OP_WBYTE: begin
               if (phase_ff == sdh_pkg::PH_WR_NEED) begin
                  phase_in = sdh_pkg::PH_WR_DATA;
                  xfer_en  = 1'b1;
                  xfer_b   = write_byte;
               end
            end
            sdh_pkg::OP_XDONE: begin
               case (phase_ff)
                  sdh_pkg::PH_PWRUP: begin
                     bcnt_in = bnext;
                     if (bnext >= 10'(sdh_pkg::POWERUP_BYTES)) begin
                        retry_in = '0;
                        start_en = 1'b1;
                     end else begin
                        xfer_en = 1'b1;
                     end
                  end
                  sdh_pkg::PH_READY: begin
                     poll_in = pnext;
                     xfer_en = 1'b1;
                     if (miso_byte == 8'hFF || pnext >= 4'(sdh_pkg::POLL_TRIES)) begin
                        phase_in = sdh_pkg::PH_FRAME;
                        bcnt_in  = '0;
                        xfer_b   = code_ff;
                     end
                  end
                  sdh_pkg::PH_FRAME: begin
                     bcnt_in = bnext;
                     xfer_en = 1'b1;
                     case (bnext)
                        10'd1:   xfer_b = arg_ff[31:24];
                        10'd2:   xfer_b = arg_ff[23:16];
                        10'd3:   xfer_b = arg_ff[15:8];
                        10'd4:   xfer_b = arg_ff[7:0];
                        10'd5:   xfer_b = sdh_pkg::crc_byte(code_ff);
                        default: begin
                           phase_in = sdh_pkg::PH_POLL;
                           poll_in  = '0;
                        end
                     endcase
                  end
                  sdh_pkg::PH_POLL: begin
                     if (!miso_byte[7]) begin
                        resp_en = 1'b1;
                     end else begin
                        poll_in = pnext;
                        if (pnext >= 4'(sdh_pkg::POLL_TRIES)) begin
                           resp_en = 1'b1;
                           resp    = 8'hFF;
                        end else begin
                           xfer_en = 1'b1;
                        end
                     end
                  end
                  sdh_pkg::PH_RD_TOKEN: begin
                     if (miso_byte == sdh_pkg::DATA_TOKEN) begin
                        phase_in = sdh_pkg::PH_RD_DATA;
                        bcnt_in  = '0;
                        xfer_en  = 1'b1;
                     end else begin
                        retry_in = rnext;
                        if (rnext >= 8'(sdh_pkg::RETRY_TRIES)) begin
                           fin_en = 1'b1;
                        end else begin
                           xfer_en = 1'b1;
                        end
                     end
                  end
                  sdh_pkg::PH_RD_DATA: begin
                     pre_en  = 1'b1;
                     xfer_en = 1'b1;
                     if (bcnt_ff >= 10'(sdh_pkg::BLOCK_BYTES - 1)) begin
                        phase_in = sdh_pkg::PH_RD_CRC;
                        bcnt_in  = '0;
                     end else begin
                        bcnt_in = bnext;
                     end
                  end
                  sdh_pkg::PH_RD_CRC: begin
                     if (bcnt_ff == '0) begin
                        bcnt_in = 10'd1;
                        xfer_en = 1'b1;
                     end else begin
                        fin_en = 1'b1;
                        fin_ok = 1'b1;
                     end
                  end
                  sdh_pkg::PH_WR_TOKEN: begin
                     phase_in = sdh_pkg::PH_WR_NEED;
                     main_en  = 1'b1;
                     main_r   = sdh_pkg::mk_res(sdh_pkg::KIND_NEED, '0, 1'b0, '0, 1'b0);
                  end
                  sdh_pkg::PH_WR_DATA: begin
                     if (bcnt_ff >= 10'(sdh_pkg::BLOCK_BYTES - 1)) begin
                        phase_in = sdh_pkg::PH_WR_CRC;
                        bcnt_in  = '0;
                        xfer_en  = 1'b1;
                     end else begin
                        bcnt_in  = bnext;
                        phase_in = sdh_pkg::PH_WR_NEED;
                        main_en  = 1'b1;
                        main_r   = sdh_pkg::mk_res(sdh_pkg::KIND_NEED, '0, 1'b0, '0, 1'b0);
                     end
                  end
                  sdh_pkg::PH_WR_CRC: begin
                     if (bcnt_ff == '0) begin
                        bcnt_in = 10'd1;
                     end else begin
                        phase_in = sdh_pkg::PH_WR_RESP;
                     end
                     xfer_en = 1'b1;
                  end
                  sdh_pkg::PH_WR_RESP: begin
                     if (miso_byte[4:0] != 5'h05) begin
                        fin_en = 1'b1;
                     end else begin
                        phase_in = sdh_pkg::PH_WR_BUSY;
                        xfer_en  = 1'b1;
                     end
                  end
                  sdh_pkg::PH_WR_BUSY: begin
                     if (miso_byte == 8'h00) begin
                        xfer_en = 1'b1;
                     end else begin
                        fin_en = 1'b1;
                        fin_ok = 1'b1;
                     end
                  end
                  sdh_pkg::PH_END_CLOCK: begin
                     start_en = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      // response handling after a command frame
      if (resp_en) begin
         sel_in = 1'b0;
         case ({1'b0, oper_ff})
            sdh_pkg::OP_INIT: begin
               case (code_ff)
                  sdh_pkg::CODE_CMD0: begin
                     if (resp == 8'h01) begin
                        start_en  = 1'b1;
                        start_idx = sdh_pkg::IDX_CMD8;
                        start_arg = sdh_pkg::CMD8_ARG;
                     end else begin
                        retry_in = rnext;
                        if (rnext >= 8'(sdh_pkg::RETRY_TRIES)) fin_en = 1'b1;
                        else start_en = 1'b1;
                     end
                  end
                  sdh_pkg::CODE_CMD8: begin
                     if (resp == 8'h01 || resp == 8'h05) begin
                        start_en  = 1'b1;
                        start_idx = sdh_pkg::IDX_CMD58;
                     end else begin
                        fin_en = 1'b1;
                     end
                  end
                  sdh_pkg::CODE_CMD58: begin
                     if (resp == 8'h01) begin
                        retry_in  = '0;
                        start_en  = 1'b1;
                        start_idx = sdh_pkg::IDX_CMD55;
                     end else begin
                        fin_en = 1'b1;
                     end
                  end
                  sdh_pkg::CODE_CMD55: begin
                     start_en = 1'b1;
                     if (resp <= 8'h01) begin
                        start_idx = sdh_pkg::IDX_ACMD41;
                        start_arg = sdh_pkg::ACMD41_ARG;
                     end else begin
                        start_idx = sdh_pkg::IDX_CMD1;
                     end
                  end
                  sdh_pkg::CODE_ACMD41, sdh_pkg::CODE_CMD1: begin
                     if (resp == 8'h00) begin
                        start_en  = 1'b1;
                        start_idx = sdh_pkg::IDX_CMD16;
                        start_arg = 32'(sdh_pkg::BLOCK_BYTES);
                     end else begin
                        retry_in = rnext;
                        if (rnext >= 8'(sdh_pkg::RETRY_TRIES)) begin
                           fin_en = 1'b1;
                        end else begin
                           start_en  = 1'b1;
                           start_idx = sdh_pkg::IDX_CMD55;
                        end
                     end
                  end
                  sdh_pkg::CODE_CMD16: begin
                     if (resp == 8'h00) begin
                        start_en  = 1'b1;
                        start_idx = sdh_pkg::IDX_CMD59;
                     end else begin
                        fin_en = 1'b1;
                     end
                  end
                  sdh_pkg::CODE_CMD59: begin
                     fin_en = 1'b1;
                     fin_ok = 1'b1;
                  end
                  default: fin_en = 1'b1;
               endcase
            end
            sdh_pkg::OP_READ: begin
               if (resp != 8'h00) begin
                  fin_en = 1'b1;
               end else begin
                  sel_in   = 1'b1;
                  retry_in = '0;
                  phase_in = sdh_pkg::PH_RD_TOKEN;
                  xfer_en  = 1'b1;
               end
            end
            sdh_pkg::OP_WRITE: begin
               if (resp != 8'h00) begin
                  fin_en = 1'b1;
               end else begin
                  sel_in   = 1'b1;
                  bcnt_in  = '0;
                  phase_in = sdh_pkg::PH_WR_TOKEN;
                  xfer_en  = 1'b1;
                  xfer_b   = sdh_pkg::DATA_TOKEN;
               end
            end
            default: begin
               fin_en = 1'b1;
               fin_ok = 1'b1;
            end
         endcase
      end

      if (start_en) begin
         code_in  = {2'b01, start_idx};
         arg_in   = start_arg;
         sel_in   = 1'b1;
         poll_in  = '0;
         phase_in = sdh_pkg::PH_READY;
         xfer_en  = 1'b1;
         xfer_b   = sdh_pkg::IDLE_BYTE;
      end
      if (fin_en) begin
         phase_in = sdh_pkg::PH_IDLE;
         sel_in   = 1'b0;
         main_en  = 1'b1;
         main_r   = sdh_pkg::mk_res(sdh_pkg::KIND_DONE, '0, 1'b0, '0, fin_ok);
      end else if (xfer_en) begin
         main_en = 1'b1;
         main_r  = sdh_pkg::mk_res(sdh_pkg::KIND_XFER, xfer_b, sel_in, '0, 1'b0);
      end

      main_r.last = 1'b1;
      push.r0 = pre_en ? pre_r : main_r;
      push.r1 = main_r;
      push.n  = {1'b0, main_en} + {1'b0, pre_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sdh_pkg::PH_IDLE;
         oper_ff      <= '0;
         bcnt_ff      <= '0;
         poll_ff      <= '0;
         retry_ff     <= '0;
         arg_ff       <= '0;
         code_ff      <= '0;
         sel_ff       <= 1'b0;
         byte_addr_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         oper_ff  <= oper_in;
         bcnt_ff  <= bcnt_in;
         poll_ff  <= poll_in;
         retry_ff <= retry_in;
         arg_ff   <= arg_in;
         code_ff  <= code_in;
         sel_ff   <= sel_in;
         if (cfg_we) byte_addr_ff <= cfg_data;
      end
   end

   a_idle_desel: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sdh_pkg::PH_IDLE |-> !sel_ff) else $error("select held while idle");
   a_two_only_read: assert property (@(posedge clock) disable iff (reset)
      push.n == 2'd2 |-> phase_ff == sdh_pkg::PH_RD_DATA) else $error("two results outside read");
   a_poll_bound: assert property (@(posedge clock) disable iff (reset)
      poll_ff <= 4'(sdh_pkg::POLL_TRIES)) else $error("poll count overrun");

endmodule

// ----- src/sdh_res_fifo.sv -----
// ----------------------------------------------------------------------------
// sdh_res_fifo
// result queue taking up to two items a cycle and giving at most one
// ----------------------------------------------------------------------------
module sdh_res_fifo (
   input  logic              clock,
   input  logic              reset,
   input  sdh_pkg::push_type push,
   input  logic              pop,
   output logic              not_empty,
   output logic              low_room,
   output sdh_pkg::res_type  head
);

   localparam int AW = $clog2(sdh_pkg::FIFO_DEPTH);

   sdh_pkg::res_type mem_ff [sdh_pkg::FIFO_DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0]   cnt_ff, cnt_in;

   always_comb begin
      wptr_in = AW'(wptr_ff + AW'(push.n));
      rptr_in = AW'(rptr_ff + AW'(pop));
      cnt_in  = (AW+1)'(cnt_ff + (AW+1)'(push.n) - (AW+1)'(pop));
   end

   assign not_empty = cnt_ff != '0;
   assign low_room  = cnt_ff > (AW+1)'(sdh_pkg::FIFO_DEPTH - 2);
   assign head      = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) mem_ff[wptr_ff] <= push.r0;
      if (push.n == 2'd2) mem_ff[AW'(wptr_ff + AW'(1))] <= push.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
